@@ rtl/hbs_pkg.sv @@
// Shared constants, types and fixed-point helpers for the bone skinning block.
package hbs_pkg;
	localparam int BONE_COUNT     = 16;
	localparam int BONE_W         = 4;
	localparam int NUM_INFLUENCES = 4;
	localparam int INF_W          = 2;
	localparam int NUM_ROT        = 9;

	localparam logic [3:0] ELEM_OFF_X  = 4'd9;
	localparam logic [3:0] ELEM_PARENT = 4'd12;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_SKIN  = 1'b1;

	typedef struct packed {
		logic              en;
		logic [BONE_W-1:0] bone;
		logic [3:0]        elem;
		logic [31:0]       value;
	} wr_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Round a Q2.14 row product sum, then add the local position.
	function automatic logic signed [31:0] finish_row(input logic signed [51:0] s,
			input logic signed [31:0] off);
		logic signed [63:0] r;
		logic signed [31:0] q;
		r = (64'(s) + 64'sd8192) >>> 14;
		q = sat32(r);
		return sat32(64'(q) + 64'(off));
	endfunction
endpackage

@@ rtl/hbs_bone_mem.sv @@
// Bone table: rotation, local position and parent memories with registered read.
module hbs_bone_mem (
	input  logic                                 clk,
	input  hbs_pkg::wr_req_t                     wr,
	input  logic [hbs_pkg::BONE_W-1:0]           rd_bone,
	output logic signed [15:0]                   rd_rot [3][3],
	output logic signed [31:0]                   rd_off [3],
	output logic [hbs_pkg::BONE_W-1:0]           rd_par
);
	import hbs_pkg::*;

	logic [15:0]       rot_mem [BONE_COUNT][NUM_ROT];
	logic [31:0]       off_mem [BONE_COUNT][3];
	logic [BONE_W-1:0] par_mem [BONE_COUNT];

	logic [15:0]       rot_q [NUM_ROT];
	logic [31:0]       off_q [3];
	logic [BONE_W-1:0] par_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.elem < ELEM_OFF_X) begin
				rot_mem[wr.bone][wr.elem] <= wr.value[15:0];
			end else if (wr.elem < ELEM_PARENT) begin
				off_mem[wr.bone][2'(wr.elem - ELEM_OFF_X)] <= wr.value;
			end else if (wr.elem == ELEM_PARENT) begin
				par_mem[wr.bone] <= wr.value[BONE_W-1:0];
			end
		end
		rot_q <= rot_mem[rd_bone];
		off_q <= off_mem[rd_bone];
		par_q <= par_mem[rd_bone];
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				rd_rot[r][c] = rot_q[r*3+c];
			end
			rd_off[r] = off_q[r];
		end
		rd_par = par_q;
	end
endmodule

@@ rtl/hierarchical_bone_skinning.sv @@
// Top level: request decode, chain-walk sequencer, shared multiplier and result register.
// A write request updates one bone table element. A skin request runs
// each of the four influences in turn: an offset walk over each bone on the
// chain, then a pose walk over each bone (memory read plus nine products
// through the one 32x17 multiplier), then a weighting of the posed point.
// Chains of up to sixteen bones are walked. The result is held in an output
// register, and a new request is taken while it waits.
module hierarchical_bone_skinning (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bone_sel, element_sel, element_value, pos_x, pos_y, pos_z,
	// influence_bones, influence_weights
	input  logic [215:0] s_tdata,
	// func
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// skinned_x, skinned_y, skinned_z
	output logic [95:0]  m_tdata
);
	import hbs_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_START = 10'b0000000010,
		ST_A_RD  = 10'b0000000100,
		ST_A_USE = 10'b0000001000,
		ST_SUB   = 10'b0000010000,
		ST_B_RD  = 10'b0000100000,
		ST_B_MUL = 10'b0001000000,
		ST_B_END = 10'b0010000000,
		ST_W_MUL = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] pos_q [3];
	logic [15:0]        bones_q;
	logic [63:0]        weights_q;
	logic [INF_W-1:0]   inf_q;
	logic [BONE_W-1:0]  cur_q;
	logic [BONE_W-1:0]  step_q;
	logic signed [31:0] off_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] q_q [3];
	logic signed [51:0] row_q;
	logic signed [63:0] wacc_q [3];

	logic               iss_q;
	logic [1:0]         ir_q;
	logic [1:0]         ic_q;
	logic               v_s1;
	logic [1:0]         ar_s1;
	logic [1:0]         ac_s1;
	logic signed [48:0] prod_s1;

	logic               m_tvalid_q;
	logic [95:0]        out_q;

	wr_req_t            wr;
	logic signed [15:0] rd_rot [3][3];
	logic signed [31:0] rd_off [3];
	logic [BONE_W-1:0]  rd_par;

	logic signed [31:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [51:0] row_sum;
	logic [BONE_W-1:0]  inf_bone;
	logic [15:0]        inf_w;
	logic               walk_end;
	logic               accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	assign wr.en    = accept && (s_tuser == FUNC_WRITE);
	assign wr.bone  = s_tdata[3:0];
	assign wr.elem  = s_tdata[7:4];
	assign wr.value = s_tdata[39:8];

	hbs_bone_mem u_mem (
		.clk    (clk),
		.wr     (wr),
		.rd_bone(cur_q),
		.rd_rot (rd_rot),
		.rd_off (rd_off),
		.rd_par (rd_par)
	);

	assign inf_bone = bones_q[inf_q*BONE_W +: BONE_W];
	assign inf_w    = weights_q[inf_q*16 +: 16];
	assign walk_end = (rd_par == cur_q) || (step_q == BONE_W'(BONE_COUNT - 1));
	assign mul_a    = p_q[ic_q];
	assign mul_b    = (state_q == ST_W_MUL) ? $signed({1'b0, inf_w})
	                                        : 17'(rd_rot[ir_q][ic_q]);
	assign row_sum  = row_q + 52'(prod_s1);

	// shared multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= iss_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		ar_s1   <= ir_q;
		ac_s1   <= ic_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			// advance the multiplier issue counters
			if (iss_q) begin
				if (ic_q == 2'd2) begin
					ic_q <= 2'd0;
					ir_q <= ir_q + 2'd1;
					if (state_q == ST_W_MUL || ir_q == 2'd2) begin
						iss_q <= 1'b0;
					end
				end else begin
					ic_q <= ic_q + 2'd1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == FUNC_SKIN) begin
						pos_q[0]  <= s_tdata[71:40];
						pos_q[1]  <= s_tdata[103:72];
						pos_q[2]  <= s_tdata[135:104];
						bones_q   <= s_tdata[151:136];
						weights_q <= s_tdata[215:152];
						inf_q     <= '0;
						for (int c = 0; c < 3; c++) begin
							wacc_q[c] <= '0;
						end
						state_q <= ST_START;
					end
				end
				ST_START: begin
					cur_q  <= inf_bone;
					step_q <= '0;
					for (int c = 0; c < 3; c++) begin
						off_q[c] <= '0;
						p_q[c]   <= pos_q[c];
					end
					state_q <= ST_A_RD;
				end
				ST_A_RD: begin
					state_q <= ST_A_USE;
				end
				ST_A_USE: begin
					for (int c = 0; c < 3; c++) begin
						off_q[c] <= sat32(64'(off_q[c]) + 64'(rd_off[c]));
					end
					if (walk_end) begin
						state_q <= ST_SUB;
					end else begin
						cur_q   <= rd_par;
						step_q  <= step_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				ST_SUB: begin
					for (int c = 0; c < 3; c++) begin
						p_q[c] <= sat32(64'(p_q[c]) - 64'(off_q[c]));
					end
					cur_q   <= inf_bone;
					step_q  <= '0;
					state_q <= ST_B_RD;
				end
				ST_B_RD: begin
					iss_q   <= 1'b1;
					ir_q    <= 2'd0;
					ic_q    <= 2'd0;
					row_q   <= '0;
					state_q <= ST_B_MUL;
				end
				ST_B_MUL: begin
					if (v_s1) begin
						if (ac_s1 == 2'd2) begin
							q_q[ar_s1] <= finish_row(row_sum, rd_off[ar_s1]);
							row_q      <= '0;
							if (ar_s1 == 2'd2) begin
								state_q <= ST_B_END;
							end
						end else begin
							row_q <= row_sum;
						end
					end
				end
				ST_B_END: begin
					for (int c = 0; c < 3; c++) begin
						p_q[c] <= q_q[c];
					end
					if (walk_end) begin
						iss_q   <= 1'b1;
						ir_q    <= 2'd0;
						ic_q    <= 2'd0;
						state_q <= ST_W_MUL;
					end else begin
						cur_q   <= rd_par;
						step_q  <= step_q + 1'b1;
						state_q <= ST_B_RD;
					end
				end
				ST_W_MUL: begin
					if (v_s1) begin
						wacc_q[ac_s1] <= wacc_q[ac_s1] + 64'(prod_s1);
						if (ac_s1 == 2'd2) begin
							if (inf_q == INF_W'(NUM_INFLUENCES - 1)) begin
								state_q <= ST_FIN;
							end else begin
								inf_q   <= inf_q + 1'b1;
								state_q <= ST_START;
							end
						end
					end
				end
				ST_FIN: begin
					// hold until the previous result is taken
					if (!m_tvalid_q || m_tready) begin
						for (int c = 0; c < 3; c++) begin
							out_q[c*32 +: 32] <= sat32((wacc_q[c] + 64'sd16384) >>> 15);
						end
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
